// ===== hw/rtl/lkv_pkg.sv =====
// Shared types, constants and state encoding for the LRU key-value cache.
package lkv_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int CAP_W           = 5;
  localparam int KEY_W           = 32;
  localparam int VAL_W           = 32;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  typedef struct packed {
    logic                    action;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    hit;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_DECIDE,
    ST_RESP,
    ST_SWEEP,
    ST_SWEEP_LAST
  } state_t;

endpackage

// ===== hw/rtl/lkv_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: control, valid bits and the tag and value memories.
//
//   Channel | Direction | Handshake            | Payload
//   in_     | input     | in_valid / in_stall  | in_item_t (action, key, value)
//   out_    | output    | out_valid / out_stall| out_item_t (read_value, hit)
//   cfg_    | input     | cfg_valid / cfg_ready| capacity, 5 bits
//
// A get sweeps the single read port of the tag memory once to match keys, and a set
// sweeps it once more to rewrite the recency ranks. Reset is synchronous and clears
// the valid bits, the entry count and the capacity (to 16); the memories are not cleared.
// The input is stalled while a transaction is in progress, and a finished get result
// waits in the output register while the next transaction is taken.
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int RW = AW;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int TW = KEY_W + RW;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_ENTRIES - 1);

  state_t                 state_r, state_nxt;
  in_item_t               req_r, req_nxt;
  logic                   hit_r, hit_nxt;
  logic [AW-1:0]          hit_slot_r, hit_slot_nxt;
  logic [RW-1:0]          hit_rank_r, hit_rank_nxt;
  logic [AW-1:0]          old_slot_r, old_slot_nxt;
  logic                   free_found_r, free_found_nxt;
  logic [AW-1:0]          free_slot_r, free_slot_nxt;
  logic [AW-1:0]          slot_r, slot_nxt;
  logic                   ins_r, ins_nxt;
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CAP_W-1:0]       cap_r, cap_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;
  logic [AW-1:0]          scan_cnt_r, scan_cnt_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]          rd_idx_r, rd_idx_nxt;

  logic [CW-1:0]    eff_cap;
  logic             evict;
  logic             in_accept;
  logic             t_we;
  logic [TW-1:0]    t_wdata;
  logic [TW-1:0]    t_rdata;
  logic [KEY_W-1:0] tag_key;
  logic [RW-1:0]    tag_rank;
  logic             v_we;
  logic [VAL_W-1:0] v_rdata;

  lkv_ram #(.WIDTH(TW), .DEPTH(MAX_ENTRIES)) u_tag_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (rd_idx_r),
    .wdata (t_wdata),
    .raddr (scan_cnt_r),
    .rdata (t_rdata)
  );

  lkv_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (slot_nxt),
    .wdata (req_r.value),
    .raddr (hit_slot_r),
    .rdata (v_rdata)
  );

  assign tag_key   = t_rdata[TW-1:RW];
  assign tag_rank  = t_rdata[RW-1:0];
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CW'(1);
    end else if (32'(cap_r) > MAX_ENTRIES) begin
      eff_cap = CW'(MAX_ENTRIES);
    end else begin
      eff_cap = CW'(cap_r);
    end
    evict = (count_r >= eff_cap) || (count_r == CW'(MAX_ENTRIES));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r == LAST_IDX) begin
          state_nxt = ST_SCAN_LAST;
        end
      end
      ST_SCAN_LAST: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (req_r.action == ACT_SET) begin
          state_nxt = ST_SWEEP;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (scan_cnt_r == LAST_IDX) begin
          state_nxt = ST_SWEEP_LAST;
        end
      end
      ST_SWEEP_LAST: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    req_nxt        = req_r;
    hit_nxt        = hit_r;
    hit_slot_nxt   = hit_slot_r;
    hit_rank_nxt   = hit_rank_r;
    old_slot_nxt   = old_slot_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    slot_nxt       = slot_r;
    ins_nxt        = ins_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    cap_nxt        = cap_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    scan_cnt_nxt   = scan_cnt_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = scan_cnt_r;
    t_we           = 1'b0;
    t_wdata        = t_rdata;
    v_we           = 1'b0;

    if (cfg_valid && cfg_ready) begin
      cap_nxt = cfg_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r) inside
      ST_IDLE: begin
        if (in_accept) begin
          req_nxt        = in_data;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          scan_cnt_nxt   = '0;
        end
      end
      ST_SCAN, ST_SWEEP: begin
        rd_vld_nxt = 1'b1;
        if (scan_cnt_r == LAST_IDX) begin
          scan_cnt_nxt = '0;
        end else begin
          scan_cnt_nxt = scan_cnt_r + AW'(1);
        end
      end
      ST_DECIDE: begin
        if (req_r.action == ACT_SET) begin
          v_we = 1'b1;
          if (hit_r) begin
            slot_nxt = hit_slot_r;
            ins_nxt  = 1'b0;
          end else begin
            ins_nxt = 1'b1;
            if (evict) begin
              valid_nxt[old_slot_r] = 1'b0;
              if (free_found_r && (free_slot_r < old_slot_r)) begin
                slot_nxt = free_slot_r;
              end else begin
                slot_nxt = old_slot_r;
              end
            end else begin
              slot_nxt  = free_slot_r;
              count_nxt = count_r + CW'(1);
            end
            valid_nxt[slot_nxt] = 1'b1;
          end
        end
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.hit       = hit_r;
          out_data_nxt.read_value = hit_r ? v_rdata : MISS_VALUE;
        end
      end
      default: begin
      end
    endcase

    if (rd_vld_r && (state_r == ST_SCAN || state_r == ST_SCAN_LAST)) begin
      if (valid_r[rd_idx_r]) begin
        if (tag_key == req_r.key) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = rd_idx_r;
          hit_rank_nxt = tag_rank;
        end
        if (tag_rank == RW'(count_r - CW'(1))) begin
          old_slot_nxt = rd_idx_r;
        end
      end else if (!free_found_r) begin
        free_found_nxt = 1'b1;
        free_slot_nxt  = rd_idx_r;
      end
    end

    if (rd_vld_r && (state_r == ST_SWEEP || state_r == ST_SWEEP_LAST)) begin
      t_we = 1'b1;
      if (rd_idx_r == slot_r) begin
        t_wdata[RW-1:0] = '0;
        if (ins_r) begin
          t_wdata[TW-1:RW] = req_r.key;
        end
      end else if (valid_r[rd_idx_r] && (ins_r || (tag_rank < hit_rank_r))) begin
        t_wdata[RW-1:0] = tag_rank + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
      scan_cnt_r  <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    hit_r        <= hit_nxt;
    hit_slot_r   <= hit_slot_nxt;
    hit_rank_r   <= hit_rank_nxt;
    old_slot_r   <= old_slot_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    slot_r       <= slot_nxt;
    ins_r        <= ins_nxt;
    out_data_r   <= out_data_nxt;
    rd_idx_r     <= rd_idx_nxt;
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(count_r))
    else $error("Entry count differs from the number of valid entries.");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_ENTRIES)
    else $error("Entry count exceeds the number of slots.");

  a_set_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && req_r.action == ACT_SET) |=> state_r == ST_SWEEP)
    else $error("A set transaction did not go on to the recency sweep.");

endmodule
